// ----- rtl/flpr_pkg.sv -----
// ----------------------------------------------------------------------------
// flpr_pkg
// Types, codes and sizing constants for the flash log pointer recovery block.
// ----------------------------------------------------------------------------
package flpr_pkg;

   localparam int MEM_BYTES    = 2097152;
   localparam int RECORD_BYTES = 32;
   localparam int SLOT_COUNT   = MEM_BYTES / RECORD_BYTES;
   localparam int LAST_SLOT    = (SLOT_COUNT > 1) ? SLOT_COUNT - 1 : 0;
   localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int ADDR_W = 22;
   localparam int WORD_W = 64;
   // Wide enough for pointer + record size against the memory size.
   localparam int CMP_W  = 26;
   localparam int PROD_W = SLOT_W + ADDR_W;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [1:0]        code_type;

   // Request codes.
   localparam code_type REQ_RECOVER = 2'd0;
   localparam code_type REQ_PROBE   = 2'd1;
   localparam code_type REQ_APPEND  = 2'd2;
   localparam code_type REQ_CLEAR   = 2'd3;

   // Result codes.
   localparam code_type RES_PROBE   = 2'd0;
   localparam code_type RES_DONE    = 2'd1;
   localparam code_type RES_APPEND  = 2'd2;
   localparam code_type RES_CLEARED = 2'd3;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // Byte address of a slot, masked to the address width.
   function automatic addr_type slot_to_addr(slot_type slot);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(slot) * PROD_W'(RECORD_BYTES);
      return prod[ADDR_W-1:0];
   endfunction

   // Midpoint of the current search window.
   function automatic slot_type slot_mid(slot_type lo, slot_type hi);
      logic [SLOT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hi};
      return sum[SLOT_W:1];
   endfunction

endpackage

// ----- rtl/flash_log_pointer_recovery.sv -----
// ----------------------------------------------------------------------------
// flash_log_pointer_recovery
// Append pointer keeper for a flash record log, with lower-bound binary
// search recovery of the pointer.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                                 | flow
//  ---------+-----------+-----------------------------------------+------------
//  req_     | in        | req_type, req_probe_word, req_probe_last | valid/stall
//  rsp_     | out       | rsp_res_type, rsp_address, rsp_status    | valid/stall
//
//  One request transfer per cycle while req_stall is low. Its result, if any,
//  is in the output register in the cycle after the transfer.
//  The search step (midpoint, compare, window update, next midpoint) is done
//  in one pass between the request port and the output register.
//  req_stall rises only while a held result is itself stalled; an empty
//  output register or a result leaving this cycle lets the next transfer in.
//  Reset (synchronous, active high) zeroes the pointer and the search window,
//  ends any search and drops a pending result.
// ----------------------------------------------------------------------------
module flash_log_pointer_recovery
   import flpr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [WORD_W-1:0] req_probe_word,
   input  logic              req_probe_last,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_res_type,
   output logic [ADDR_W-1:0] rsp_address,
   output logic              rsp_status
);

   // Architectural state.
   addr_type append_pointer_ff, append_pointer_in;
   slot_type search_low_ff,     search_low_in;
   slot_type search_high_ff,    search_high_in;
   logic     search_active_ff,  search_active_in;
   logic     all_ones_ff,       all_ones_in;

   // Output register.
   logic     rsp_valid_ff,  rsp_valid_in;
   code_type rsp_type_ff,   rsp_type_in;
   addr_type rsp_addr_ff,   rsp_addr_in;
   logic     rsp_status_ff, rsp_status_in;

   logic     out_free;
   logic     req_fire;

   // Search step working values.
   slot_type         mid;
   slot_type         step_low;
   slot_type         step_high;
   logic [SLOT_W:0]  mid_plus;
   logic             word_ones;
   logic             rec_ones;
   logic [CMP_W-1:0] append_sum;

   // The output register takes a new result when empty or when its
   // current result leaves this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign req_fire  = req_valid && out_free;

   assign mid        = slot_mid(search_low_ff, search_high_ff);
   assign mid_plus   = {1'b0, mid} + {{SLOT_W{1'b0}}, 1'b1};
   assign word_ones  = &req_probe_word;
   assign rec_ones   = all_ones_ff && word_ones;
   assign append_sum = CMP_W'(append_pointer_ff) + CMP_W'(RECORD_BYTES);

   // Window after the probed record: erased keeps mid as the upper bound,
   // written moves the lower bound past mid. Clamp a crossed window.
   always_comb begin
      step_high = search_high_ff;
      step_low  = search_low_ff;
      if (rec_ones) begin
         step_high = mid;
      end else begin
         step_low = mid_plus[SLOT_W-1:0];
      end
      if (step_low > step_high) begin
         step_low = step_high;
      end
   end

   always_comb begin
      append_pointer_in = append_pointer_ff;
      search_low_in     = search_low_ff;
      search_high_in    = search_high_ff;
      search_active_in  = search_active_ff;
      all_ones_in       = all_ones_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_type_in   = rsp_type_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      if (req_fire) begin
         if (search_active_ff) begin
            // Commands are dropped while a search runs; only words count.
            if (req_type == REQ_PROBE) begin
               all_ones_in = rec_ones;
               if (req_probe_last) begin
                  all_ones_in    = 1'b1;
                  search_low_in  = step_low;
                  search_high_in = step_high;
                  rsp_valid_in   = 1'b1;
                  if (step_low == step_high) begin
                     // Window closed: first erased slot found (the last slot if none is erased).
                     search_active_in  = 1'b0;
                     append_pointer_in = slot_to_addr(step_low);
                     rsp_type_in       = RES_DONE;
                     rsp_addr_in       = slot_to_addr(step_low);
                     rsp_status_in     = (step_low == SLOT_W'(LAST_SLOT)) ?
                                         STATUS_ERROR : STATUS_OK;
                  end else begin
                     rsp_type_in   = RES_PROBE;
                     rsp_addr_in   = slot_to_addr(slot_mid(step_low, step_high));
                     rsp_status_in = STATUS_OK;
                  end
               end
            end
         end else begin
            unique case (req_type)
               REQ_RECOVER: begin
                  search_low_in  = '0;
                  search_high_in = SLOT_W'(LAST_SLOT);
                  all_ones_in    = 1'b1;
                  rsp_valid_in   = 1'b1;
                  if (LAST_SLOT == 0) begin
                     // Single slot: nothing to search.
                     search_active_in  = 1'b0;
                     append_pointer_in = '0;
                     rsp_type_in       = RES_DONE;
                     rsp_addr_in       = '0;
                     rsp_status_in     = STATUS_ERROR;
                  end else begin
                     search_active_in = 1'b1;
                     rsp_type_in      = RES_PROBE;
                     rsp_addr_in      = slot_to_addr(slot_mid('0, SLOT_W'(LAST_SLOT)));
                     rsp_status_in    = STATUS_OK;
                  end
               end
               REQ_APPEND: begin
                  rsp_valid_in = 1'b1;
                  rsp_type_in  = RES_APPEND;
                  rsp_addr_in  = append_pointer_ff;
                  if (append_sum > CMP_W'(MEM_BYTES)) begin
                     rsp_status_in = STATUS_ERROR;
                  end else begin
                     rsp_status_in     = STATUS_OK;
                     append_pointer_in = append_sum[ADDR_W-1:0];
                  end
               end
               REQ_CLEAR: begin
                  append_pointer_in = '0;
                  rsp_valid_in      = 1'b1;
                  rsp_type_in       = RES_CLEARED;
                  rsp_addr_in       = '0;
                  rsp_status_in     = STATUS_OK;
               end
               default: begin
                  // Word outside a search: drop it.
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         append_pointer_ff <= '0;
         search_low_ff     <= '0;
         search_high_ff    <= '0;
         search_active_ff  <= 1'b0;
         all_ones_ff       <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         append_pointer_ff <= append_pointer_in;
         search_low_ff     <= search_low_in;
         search_high_ff    <= search_high_in;
         search_active_ff  <= search_active_in;
         all_ones_ff       <= all_ones_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload holds while stalled; no reset needed.
   always_ff @(posedge clock) begin
      rsp_type_ff   <= rsp_type_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_type = rsp_type_ff;
   assign rsp_address  = rsp_addr_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef SYNTHESIS
   a_window_ordered : assert property (@(posedge clock) disable iff (reset)
      search_active_ff |-> (search_low_ff < search_high_ff))
      else $error("search window empty or crossed while searching");

   a_idle_all_ones : assert property (@(posedge clock) disable iff (reset)
      !search_active_ff |-> all_ones_ff)
      else $error("erased flag not rearmed outside a search");

   a_pointer_in_range : assert property (@(posedge clock) disable iff (reset)
      CMP_W'(append_pointer_ff) <= CMP_W'(MEM_BYTES))
      else $error("append pointer beyond memory");

   a_last_word_answers : assert property (@(posedge clock) disable iff (reset)
      (req_fire && search_active_ff && req_type == REQ_PROBE && req_probe_last)
      |=> (rsp_valid_ff && (rsp_type_ff == RES_PROBE || rsp_type_ff == RES_DONE)))
      else $error("final probe word gave no probe request or done");

   a_done_ends_search : assert property (@(posedge clock) disable iff (reset)
      (req_fire && search_active_ff && req_type == REQ_PROBE && req_probe_last)
      |=> (search_active_ff == (rsp_type_ff == RES_PROBE)))
      else $error("search activity disagrees with result kind");
`endif

endmodule

// ----- tb/sv/tb_flash_log_pointer_recovery.sv -----
// ----------------------------------------------------------------------------
// tb_flash_log_pointer_recovery
// Self-checking bench for the flash log pointer recovery block. Every accepted
// request runs through a cycle-free model of the append pointer and search
// window; the results it implies are queued and compared, field by field and
// in order, with the transfers that leave the result port. Stimulus covers
// clears, appends up to and past a full log, and recovery searches against
// simulated flash contents, with stray words and commands mixed in.
// ----------------------------------------------------------------------------
module tb_flash_log_pointer_recovery;
   import flpr_pkg::*;

   localparam int TARGET_ITEMS   = 550;
   localparam int STALL_PCT      = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 20;
   localparam logic [WORD_W-1:0] ERASED_WORD = '1;

   typedef struct packed {
      code_type kind;
      addr_type addr;
      logic     status;
   } log_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_type = REQ_CLEAR;
   logic [WORD_W-1:0] req_probe_word = '0;
   logic              req_probe_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_res_type;
   logic [ADDR_W-1:0] rsp_address;
   logic              rsp_status;

   // Model of the block: append pointer, search window and erased flag.
   addr_type ptr_model     = '0;
   int       win_lo        = 0;
   int       win_hi        = 0;
   bit       searching     = 1'b0;
   bit       record_erased = 1'b1;

   log_result_type awaited_results[$];

   // While set, neither side idles.
   bit steady = 1'b0;

   int errors      = 0;
   int items_taken = 0;
   int n_ignored   = 0;
   int n_probes    = 0;
   int n_recovered = 0;
   int n_full      = 0;
   int n_appends   = 0;
   int n_no_room   = 0;
   int n_clears    = 0;
   int idle_cycles = 0;

   flash_log_pointer_recovery u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_probe_word (req_probe_word),
      .req_probe_last (req_probe_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_res_type   (rsp_res_type),
      .rsp_address    (rsp_address),
      .rsp_status     (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (errors < MAX_REPORTS) begin
         $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      end
      errors++;
   endtask

   task automatic expect_result(input code_type kind, input addr_type addr, input logic status);
      log_result_type r;
      r.kind   = kind;
      r.addr   = addr;
      r.status = status;
      awaited_results.push_back(r);
   endtask

   // Close the search when the window has shrunk to one slot, else ask for
   // the midpoint slot.
   task automatic search_advance();
      if (win_lo == win_hi) begin
         searching = 1'b0;
         ptr_model = addr_type'(win_lo * RECORD_BYTES);
         expect_result(RES_DONE, ptr_model, (win_lo == LAST_SLOT) ? STATUS_ERROR : STATUS_OK);
      end else begin
         searching = 1'b1;
         expect_result(RES_PROBE, addr_type'(((win_lo + win_hi) / 2) * RECORD_BYTES),
                       STATUS_OK);
      end
   endtask

   // Apply one accepted request; used is low when the block ignores it.
   task automatic predict_log_step(input code_type kind, input logic [WORD_W-1:0] word,
                                   input logic last, output bit used);
      int mid;
      used = 1'b1;
      if (searching) begin
         if (kind != REQ_PROBE) begin
            used = 1'b0;
         end else begin
            if (word != ERASED_WORD) record_erased = 1'b0;
            if (last) begin
               mid = (win_lo + win_hi) / 2;
               // Lower-bound step: an erased probe keeps mid in the window.
               if (record_erased) win_hi = mid;
               else win_lo = mid + 1;
               if (win_lo > win_hi) win_lo = win_hi;
               record_erased = 1'b1;
               search_advance();
            end
         end
      end else begin
         case (kind)
            REQ_RECOVER: begin
               win_lo        = 0;
               win_hi        = LAST_SLOT;
               record_erased = 1'b1;
               search_advance();
            end
            REQ_APPEND: begin
               if (int'(ptr_model) + RECORD_BYTES > MEM_BYTES) begin
                  expect_result(RES_APPEND, ptr_model, STATUS_ERROR);
               end else begin
                  expect_result(RES_APPEND, ptr_model, STATUS_OK);
                  ptr_model = addr_type'(int'(ptr_model) + RECORD_BYTES);
               end
            end
            REQ_CLEAR: begin
               ptr_model = '0;
               expect_result(RES_CLEARED, '0, STATUS_OK);
            end
            default: used = 1'b0;
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // A word that marks its record as written: often all ones but one bit.
   function automatic logic [WORD_W-1:0] written_word();
      logic [WORD_W-1:0] w;
      if ($urandom_range(1) == 1) begin
         w = ERASED_WORD;
         w[$urandom_range(WORD_W - 1)] = 1'b0;
      end else begin
         w = rand_word();
      end
      return w;
   endfunction

   // Enter and leave at a falling edge. Valid stays high on return so that a
   // back-to-back transfer needs only one assignment per step; the caller
   // either sends again or drops valid at that same edge.
   task automatic send_item(input code_type kind, input logic [WORD_W-1:0] word,
                            input logic last);
      bit used;
      if (!steady && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_probe_word <= word;
      req_probe_last <= last;
      do @(posedge clock); while (req_stall);
      predict_log_step(kind, word, last, used);
      if (used) items_taken++;
      else n_ignored++;
      @(negedge clock);
   endtask

   // Answer probes until the search closes. Slots below the boundary hold a
   // record, the rest are erased; scrambled answers ignore the boundary.
   task automatic answer_probes(input int boundary, input int max_words,
                                input int noise_pct, input bit scrambled);
      int          mid;
      int          nwords;
      int          dirty_at;
      bit          erased;
      code_type    noise_kind;
      logic [WORD_W-1:0] word;
      while (searching) begin
         mid      = (win_lo + win_hi) / 2;
         erased   = scrambled ? bit'($urandom_range(1)) : (mid >= boundary);
         nwords   = $urandom_range(1, max_words);
         dirty_at = $urandom_range(0, nwords - 1);
         for (int w = 0; w < nwords; w++) begin
            // Commands during a search must be dropped by the block.
            if ($urandom_range(99) < noise_pct) begin
               case ($urandom_range(2))
                  0:       noise_kind = REQ_RECOVER;
                  1:       noise_kind = REQ_APPEND;
                  default: noise_kind = REQ_CLEAR;
               endcase
               send_item(noise_kind, rand_word(), 1'($urandom_range(1)));
            end
            word = (erased || w != dirty_at) ? ERASED_WORD : written_word();
            send_item(REQ_PROBE, word, w == nwords - 1);
         end
      end
   endtask

   function automatic int pick_boundary();
      case ($urandom_range(9))
         0:       return 0;
         1:       return SLOT_COUNT;
         2, 3:    return $urandom_range(SLOT_COUNT - 4, SLOT_COUNT);
         4:       return $urandom_range(1, 8);
         default: return $urandom_range(0, SLOT_COUNT);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Append from reset, clear, and stray probe words with no search running.
   task automatic test_clear_and_append();
      send_item(REQ_APPEND, rand_word(), 1'b1);
      send_item(REQ_APPEND, ERASED_WORD, 1'b0);
      send_item(REQ_CLEAR, '0, 1'b0);
      send_item(REQ_APPEND, rand_word(), 1'b0);
      send_item(REQ_PROBE, ERASED_WORD, 1'b1);
      send_item(REQ_PROBE, '0, 1'b0);
   endtask

   // Every slot written: the search ends on the last slot and flags a full
   // log. The first record is split over two words and commands sent during
   // the search are ignored. Then fill the last slot and overrun the log.
   task automatic test_full_log();
      send_item(REQ_RECOVER, rand_word(), 1'b1);
      send_item(REQ_CLEAR, rand_word(), 1'b1);
      send_item(REQ_APPEND, rand_word(), 1'b0);
      send_item(REQ_RECOVER, rand_word(), 1'b0);
      send_item(REQ_PROBE, ERASED_WORD, 1'b0);
      answer_probes(SLOT_COUNT, 1, 0, 1'b0);
      send_item(REQ_APPEND, rand_word(), 1'b1);
      send_item(REQ_APPEND, rand_word(), 1'b1);
      send_item(REQ_APPEND, ERASED_WORD, 1'b0);
   endtask

   // Mostly well-formed searches against random flash contents, mixed with
   // append bursts, clears and stray words; some searches are scrambled.
   task automatic test_random_traffic();
      int pick;
      while (items_taken < TARGET_ITEMS) begin
         // Hold both sides busy for one stretch in the middle.
         steady = (items_taken >= 200 && items_taken < 320);
         pick   = $urandom_range(99);
         if (pick < 45) begin
            send_item(REQ_RECOVER, rand_word(), 1'($urandom_range(1)));
            answer_probes(pick_boundary(), 4, 5, $urandom_range(9) == 0);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 6))
               send_item(REQ_APPEND, rand_word(), 1'($urandom_range(1)));
         end else if (pick < 88) begin
            send_item(REQ_CLEAR, rand_word(), 1'($urandom_range(1)));
         end else begin
            repeat ($urandom_range(1, 3))
               send_item(REQ_PROBE, rand_word(), 1'($urandom_range(1)));
         end
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < STALL_PCT);
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      log_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result, type", rsp_res_type, -1);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_res_type !== want.kind)
               report_mismatch("result type", rsp_res_type, want.kind);
            if (rsp_address !== want.addr)
               report_mismatch("address", rsp_address, want.addr);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            case (want.kind)
               RES_PROBE: n_probes++;
               RES_DONE: begin
                  n_recovered++;
                  if (want.status == STATUS_ERROR) n_full++;
               end
               RES_APPEND: begin
                  n_appends++;
                  if (want.status == STATUS_ERROR) n_no_room++;
               end
               default: n_clears++;
            endcase
         end
      end
   end

   // End the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, awaited_results.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_clear_and_append();
      test_full_log();
      test_random_traffic();
      req_valid <= 1'b0;

      // Drain, then keep the clock running so that any extra result shows.
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (awaited_results.size() != 0)
         report_mismatch("results never delivered", 0, awaited_results.size());

      $display("covered %0d requests (%0d ignored), %0d probe requests, %0d recoveries (%0d full)",
               items_taken, n_ignored, n_probes, n_recovered, n_full);
      $display("covered %0d appends (%0d without room), %0d clears, %0d mismatches",
               n_appends, n_no_room, n_clears, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
